/* rtl/core/npfrm_pkg.sv */
// Package for the product-form sparse ring multiplier.
// Holds sizes, operation codes, request and response types and the
// command and status types between the controller and the datapath.
package npfrm_pkg;

    localparam int MAX_DEGREE  = 1024;
    localparam int DEG_W       = $clog2(MAX_DEGREE);
    localparam int MAX_WEIGHT  = 64;
    localparam int WEIGHT_W    = 7;
    localparam int INDEX_DEPTH = 6 * MAX_WEIGHT;
    localparam int IPTR_W      = $clog2(INDEX_DEPTH);
    localparam int COEF_W      = 11;
    localparam int NDEG_W      = 11;
    localparam int TERM_W      = WEIGHT_W + 1;
    localparam int MODBIT_W    = 4;

    localparam logic [1:0] OP_LOAD_DENSE = 2'd0;
    localparam logic [1:0] OP_LOAD_INDEX = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;
    localparam logic [1:0] OP_READ       = 2'd3;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] CFG_RING_DEGREE = 2'd0;
    localparam logic [1:0] CFG_FIRST_W     = 2'd1;
    localparam logic [1:0] CFG_SECOND_W    = 2'd2;
    localparam logic [1:0] CFG_ADDEND_W    = 2'd3;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_ADDEND = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [COEF_W-1:0] coefficient_in;
        logic [9:0]        sparse_index;
        logic [9:0]        read_address;
    } req_t;

    typedef struct packed {
        logic              result_kind;
        logic [COEF_W-1:0] coefficient_out;
        logic              index_error;
    } rsp_t;

    typedef struct packed {
        logic load_dense;
        logic load_index;
        logic start;
        logic clear;
        logic next_phase;
        logic idx_latch;
        logic mod_step;
        logic sweep_start;
        logic sweep;
        logic read_issue;
        logic out_read;
        logic out_done;
    } cmd_t;

    typedef struct packed {
        logic i_last;
        logic more_terms;
        logic last_phase;
        logic mod_last;
        logic out_busy;
    } status_t;

endpackage

/* rtl/core/ntru_product_form_ring_multiply.sv */
// Top level of the product-form sparse ring multiplier over Z_2048[X]/(X^N-1).
// A load is done in the idle state; a read is answered from the registered read of
// the result memory, passed on by the output register that the read-out state loads.
// A compute's rotate-accumulate sweep reads each memory's single port once per coefficient.
// Reset restores the register defaults and empties the pointers and error flag.
// Depends on npfrm_pkg, npfrm_ctrl and npfrm_datapath.
module ntru_product_form_ring_multiply (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [10:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  npfrm_pkg::req_t       in_req,
    output logic                  out_valid,
    input  logic                  out_stall,
    output npfrm_pkg::rsp_t       out_rsp
);
    import npfrm_pkg::*;

    cmd_t    cmd;
    status_t status;

    npfrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (in_req.operation),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .status    (status)
    );

    npfrm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_req    (in_req),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !out_valid)
        else $error("Request accepted while a response is pending.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_rsp.result_kind == KIND_DONE) |-> (out_rsp.coefficient_out == '0))
        else $error("Compute response carries a nonzero coefficient.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_req.operation == OP_READ) |=> ##1 out_valid)
        else $error("Read request produced no response.");

endmodule

/* rtl/core/npfrm_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module npfrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/npfrm_ctrl.sv */
// Controller state machine of the product-form sparse ring multiplier.
// Depends on npfrm_pkg; drives the datapath by commands and reads its status.
module npfrm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             operation,
    output logic                   in_stall,
    output npfrm_pkg::cmd_t        cmd,
    input  npfrm_pkg::status_t     status
);
    import npfrm_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLEAR  = 4'd1;
    localparam logic [3:0] ST_NEXT   = 4'd2;
    localparam logic [3:0] ST_IDXLAT = 4'd3;
    localparam logic [3:0] ST_MOD    = 4'd4;
    localparam logic [3:0] ST_SINIT  = 4'd5;
    localparam logic [3:0] ST_SWEEP  = 4'd6;
    localparam logic [3:0] ST_DONE   = 4'd7;
    localparam logic [3:0] ST_RDOUT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE) || status.out_busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_LOAD_DENSE: cmd.load_dense = 1'b1;
                        OP_LOAD_INDEX: cmd.load_index = 1'b1;
                        OP_COMPUTE:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = ST_RDOUT;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.i_last)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (status.more_terms)
                begin
                    state_next = ST_IDXLAT;
                end
                else if (status.last_phase)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.next_phase = 1'b1;
                end
            end
            ST_IDXLAT:
            begin
                cmd.idx_latch = 1'b1;
                state_next    = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = ST_SINIT;
                end
            end
            ST_SINIT:
            begin
                cmd.sweep_start = 1'b1;
                state_next      = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (status.i_last)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_DONE:
            begin
                cmd.out_done = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_RDOUT:
            begin
                cmd.out_read = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/npfrm_datapath.sv */
// Datapath of the product-form sparse ring multiplier: configuration,
// operand and result memories, index reduction and the rotate-accumulate sweep.
// Depends on npfrm_pkg and npfrm_ram.
module npfrm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [npfrm_pkg::NDEG_W-1:0]  cfg_data,
    input  npfrm_pkg::req_t               in_req,
    input  npfrm_pkg::cmd_t               cmd,
    output npfrm_pkg::status_t            status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output npfrm_pkg::rsp_t               out_rsp
);
    import npfrm_pkg::*;

    logic [NDEG_W-1:0]   ring_degree_reg;
    logic [WEIGHT_W-1:0] w1_reg;
    logic [WEIGHT_W-1:0] w2_reg;
    logic [WEIGHT_W-1:0] w3_reg;
    logic [DEG_W:0]      dense_ptr_reg;
    logic [IPTR_W-1:0]   idx_ptr_reg;
    logic                err_reg;
    logic [1:0]          phase_reg;
    logic [TERM_W-1:0]   term_reg;
    logic [IPTR_W-1:0]   pos_reg;
    logic [DEG_W-1:0]    i_reg;
    logic [DEG_W-1:0]    s_reg;
    logic [DEG_W-1:0]    r_reg;
    logic [MODBIT_W-1:0] bit_reg;
    logic                neg_reg;
    logic                wb_valid_reg;
    logic [DEG_W-1:0]    wb_addr_reg;
    logic                in_range_reg;
    logic [NDEG_W-1:0]   res_fill_reg;
    logic                out_valid_reg;
    rsp_t                out_reg;

    logic [NDEG_W-1:0]   n_eff;
    logic [DEG_W-1:0]    n_last;
    logic [WEIGHT_W-1:0] w_raw;
    logic [WEIGHT_W-1:0] w_cur;
    logic [DEG_W+9:0]    n_shift;
    logic [COEF_W-1:0]   dense_rdata;
    logic [COEF_W-1:0]   part_rdata;
    logic [COEF_W-1:0]   res_rdata;
    logic [DEG_W-1:0]    idx_rdata;
    logic [COEF_W-1:0]   dst_val;
    logic [COEF_W-1:0]   src_val;
    logic [COEF_W-1:0]   wb_val;
    logic                dense_we;
    logic                index_we;
    logic                part_we;
    logic                res_we;
    logic [DEG_W-1:0]    part_waddr;
    logic [COEF_W-1:0]   part_wdata;
    logic [DEG_W-1:0]    part_raddr;
    logic [DEG_W-1:0]    res_raddr;

    always_comb
    begin
        if (ring_degree_reg == '0)
        begin
            n_eff = NDEG_W'(1);
        end
        else if (ring_degree_reg > NDEG_W'(MAX_DEGREE))
        begin
            n_eff = NDEG_W'(MAX_DEGREE);
        end
        else
        begin
            n_eff = ring_degree_reg;
        end
    end

    assign n_last = DEG_W'(n_eff - NDEG_W'(1));

    always_comb
    begin
        case (phase_reg)
            PH_FIRST:  w_raw = w1_reg;
            PH_SECOND: w_raw = w2_reg;
            default:   w_raw = w3_reg;
        endcase
    end

    assign w_cur   = (w_raw > WEIGHT_W'(MAX_WEIGHT)) ? WEIGHT_W'(MAX_WEIGHT) : w_raw;
    assign n_shift = (DEG_W+10)'(n_eff) << bit_reg;

    assign status.i_last     = (i_reg == n_last);
    assign status.more_terms = (term_reg < {w_cur, 1'b0});
    assign status.last_phase = (phase_reg == PH_ADDEND);
    assign status.mod_last   = (bit_reg == '0);
    assign status.out_busy   = out_valid_reg;

    assign dst_val = (phase_reg == PH_FIRST) ? part_rdata : res_rdata;
    assign src_val = (phase_reg == PH_SECOND) ? part_rdata : dense_rdata;
    assign wb_val  = neg_reg ? (dst_val - src_val) : (dst_val + src_val);

    assign dense_we   = cmd.load_dense && (dense_ptr_reg < (DEG_W+1)'(MAX_DEGREE));
    assign index_we   = cmd.load_index && (idx_ptr_reg < IPTR_W'(INDEX_DEPTH));
    assign part_we    = cmd.clear || (wb_valid_reg && (phase_reg == PH_FIRST));
    assign res_we     = cmd.clear || (wb_valid_reg && (phase_reg != PH_FIRST));
    assign part_waddr = cmd.clear ? i_reg : wb_addr_reg;
    assign part_wdata = cmd.clear ? '0 : wb_val;
    assign part_raddr = (phase_reg == PH_SECOND) ? s_reg : i_reg;
    assign res_raddr  = cmd.sweep ? i_reg : in_req.read_address;

    npfrm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_DEGREE)) u_dense (
        .clk   (clk),
        .we    (dense_we),
        .waddr (dense_ptr_reg[DEG_W-1:0]),
        .wdata (in_req.coefficient_in),
        .raddr (s_reg),
        .rdata (dense_rdata)
    );

    npfrm_ram #(.WIDTH(DEG_W), .DEPTH(INDEX_DEPTH)) u_index (
        .clk   (clk),
        .we    (index_we),
        .waddr (idx_ptr_reg),
        .wdata (in_req.sparse_index),
        .raddr (pos_reg),
        .rdata (idx_rdata)
    );

    npfrm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_DEGREE)) u_partial (
        .clk   (clk),
        .we    (part_we),
        .waddr (part_waddr),
        .wdata (part_wdata),
        .raddr (part_raddr),
        .rdata (part_rdata)
    );

    npfrm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_DEGREE)) u_result (
        .clk   (clk),
        .we    (res_we),
        .waddr (part_waddr),
        .wdata (part_wdata),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_degree_reg <= NDEG_W'(401);
            w1_reg          <= WEIGHT_W'(8);
            w2_reg          <= WEIGHT_W'(8);
            w3_reg          <= WEIGHT_W'(6);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RING_DEGREE: ring_degree_reg <= cfg_data;
                CFG_FIRST_W:     w1_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_SECOND_W:    w2_reg <= cfg_data[WEIGHT_W-1:0];
                default:         w3_reg <= cfg_data[WEIGHT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dense_ptr_reg <= '0;
            idx_ptr_reg   <= '0;
            err_reg       <= 1'b0;
            phase_reg     <= PH_FIRST;
            term_reg      <= '0;
            pos_reg       <= '0;
            i_reg         <= '0;
            s_reg         <= '0;
            r_reg         <= '0;
            bit_reg       <= '0;
            neg_reg       <= 1'b0;
            wb_valid_reg  <= 1'b0;
            wb_addr_reg   <= '0;
            in_range_reg  <= 1'b0;
            res_fill_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            wb_valid_reg <= cmd.sweep;
            wb_addr_reg  <= i_reg;
            if (dense_we)
            begin
                dense_ptr_reg <= dense_ptr_reg + (DEG_W+1)'(1);
            end
            if (index_we)
            begin
                idx_ptr_reg <= idx_ptr_reg + IPTR_W'(1);
            end
            if (cmd.start)
            begin
                dense_ptr_reg <= '0;
                idx_ptr_reg   <= '0;
                err_reg       <= 1'b0;
                phase_reg     <= PH_FIRST;
                term_reg      <= '0;
                pos_reg       <= '0;
                i_reg         <= '0;
                res_fill_reg  <= n_eff;
            end
            if (cmd.clear)
            begin
                i_reg <= status.i_last ? '0 : i_reg + DEG_W'(1);
            end
            if (cmd.next_phase)
            begin
                phase_reg <= phase_reg + 2'd1;
                term_reg  <= '0;
            end
            if (cmd.idx_latch)
            begin
                r_reg   <= idx_rdata;
                bit_reg <= MODBIT_W'(DEG_W - 1);
                if ((NDEG_W)'(idx_rdata) >= n_eff)
                begin
                    err_reg <= 1'b1;
                end
            end
            if (cmd.mod_step)
            begin
                if ((DEG_W+10)'(r_reg) >= n_shift)
                begin
                    r_reg <= DEG_W'((DEG_W+10)'(r_reg) - n_shift);
                end
                bit_reg <= bit_reg - MODBIT_W'(1);
            end
            if (cmd.sweep_start)
            begin
                i_reg   <= '0;
                s_reg   <= (r_reg == '0) ? '0 : DEG_W'(n_eff - NDEG_W'(r_reg));
                neg_reg <= (term_reg >= TERM_W'(w_cur));
            end
            if (cmd.sweep)
            begin
                i_reg <= i_reg + DEG_W'(1);
                s_reg <= (s_reg == n_last) ? '0 : s_reg + DEG_W'(1);
                if (status.i_last)
                begin
                    term_reg <= term_reg + TERM_W'(1);
                    pos_reg  <= pos_reg + IPTR_W'(1);
                end
            end
            if (cmd.read_issue)
            begin
                in_range_reg <= (NDEG_W'(in_req.read_address) < n_eff)
                             && (NDEG_W'(in_req.read_address) < res_fill_reg);
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.out_done)
            begin
                out_valid_reg           <= 1'b1;
                out_reg.result_kind     <= KIND_DONE;
                out_reg.coefficient_out <= '0;
                out_reg.index_error     <= err_reg;
            end
            if (cmd.out_read)
            begin
                out_valid_reg           <= 1'b1;
                out_reg.result_kind     <= KIND_READ;
                out_reg.coefficient_out <= in_range_reg ? res_rdata : '0;
                out_reg.index_error     <= err_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

endmodule
